### rtl/core/console_memory_bus_decoder_core_assert.svh
// Assertion macros shared by the memory bus decoder RTL.
`ifndef CONSOLE_MEMORY_BUS_DECODER_CORE_ASSERT_SVH
`define CONSOLE_MEMORY_BUS_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cmbd_pkg.sv
// Types, constants and address decode shared by the memory bus decoder.
package cmbd_pkg;

  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_DIV      = 16'hFF04;
  localparam logic [15:0] ADDR_LY       = 16'hFF44;
  localparam logic [15:0] ADDR_JOYP     = 16'hFF00;
  localparam logic [15:0] ADDR_ECHO     = 16'hE000;
  localparam logic [15:0] ADDR_UNUSABLE = 16'hFEA0;
  localparam logic [15:0] ADDR_HRAM     = 16'hFF80;
  localparam logic [7:0]  SPR_BYTES     = 8'hA0;
  localparam logic [7:0]  JOYP_SEL_MASK = 8'h30;

  typedef enum logic [3:0] {
    RG_CART,
    RG_VRAM,
    RG_WRAM,
    RG_SPR,
    RG_UNUSED,
    RG_JOYP,
    RG_IO,
    RG_HRAM,
    RG_IE
  } region_t;

  typedef struct packed {
    logic        en;
    logic [15:0] addr;
    logic [3:0]  btn;
    logic [3:0]  dir;
  } rd_req_t;

  typedef struct packed {
    logic        en;
    region_t     region;
    logic [12:0] idx;
    logic [7:0]  data;
  } wr_req_t;

  function automatic region_t region_of(logic [15:0] a);
    region_t r;
    if (a < 16'h8000) r = RG_CART;
    else if (a < 16'hA000) r = RG_VRAM;
    else if (a < 16'hC000) r = RG_CART;
    else if (a < 16'hFE00) r = RG_WRAM;
    else if (a < ADDR_UNUSABLE) r = RG_SPR;
    else if (a < 16'hFF00) r = RG_UNUSED;
    else if (a == ADDR_JOYP) r = RG_JOYP;
    else if (a < ADDR_HRAM) r = RG_IO;
    else if (a < 16'hFFFF) r = RG_HRAM;
    else r = RG_IE;
    return r;
  endfunction

  // A page is in cartridge space when its first byte lies below video RAM
  // or in the external RAM window.
  function automatic logic page_is_cart(logic [7:0] page);
    return (page[7] == 1'b0) || (page[7:5] == 3'b101);
  endfunction

endpackage

### rtl/core/console_memory_bus_decoder_core.sv
// Memory bus decoder top level: handshake, access pipeline and sprite DMA.
// A word is accepted every cycle unless clearing, a sprite DMA or a stalled output holds s_tready low;
// its result passes through the s1 stage register and then into the output register. A sprite DMA write
// from a non-cartridge page drops s_tready until its 160 reads and the final sprite table write are done.
// After reset a clearing pass over all 8192 addresses zeroes every array; no word is accepted meanwhile.
`include "console_memory_bus_decoder_core_assert.svh"
module console_memory_bus_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // address[15:0], write_data[23:16], buttons[27:24], dpad[31:28]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // read_data[7:0]
  output logic [1:0]  m_tuser   // cart_request[0], dma_from_cart[1]
);
  import cmbd_pkg::*;

  logic        acc;
  logic        out_free;
  logic        clr_busy;
  logic [7:0]  rd_value;
  rd_req_t     rd;
  wr_req_t     wr;

  logic        in_write;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [3:0]  in_btn, in_dir;
  region_t     in_region;
  logic        in_cart;
  logic        in_dma;
  logic        in_store;

  logic        s1_valid, s1_is_read, s1_cart, s1_dma_cart;

  logic        dma_active;
  logic [7:0]  dma_cnt;
  logic [7:0]  dma_src;
  logic [3:0]  dma_btn, dma_dir;
  logic        dma_wr_pend;
  logic [7:0]  dma_wr_idx;
  logic        dma_issue;

  assign in_write  = s_tuser[0];
  assign in_addr   = s_tdata[15:0];
  assign in_data   = s_tdata[23:16];
  assign in_btn    = s_tdata[27:24];
  assign in_dir    = s_tdata[31:28];
  assign in_region = region_of(in_addr);
  assign in_cart   = (in_region == RG_CART);
  assign in_dma    = (in_addr == ADDR_DMA);

  assign in_store = (in_region != RG_CART) && (in_region != RG_UNUSED)
                    && (in_addr != ADDR_LY) && !in_dma;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !clr_busy && !dma_active && (!s1_valid || out_free);
  assign acc       = s_tvalid && s_tready;
  assign dma_issue = dma_active && (dma_cnt < SPR_BYTES);

  always_comb begin
    rd.en   = (acc && !in_write) || dma_issue;
    rd.addr = dma_issue ? {dma_src, dma_cnt} : in_addr;
    rd.btn  = dma_issue ? dma_btn : in_btn;
    rd.dir  = dma_issue ? dma_dir : in_dir;
  end

  always_comb begin
    if (dma_wr_pend) begin
      wr.en     = 1'b1;
      wr.region = RG_SPR;
      wr.idx    = {5'd0, dma_wr_idx};
      wr.data   = rd_value;
    end else begin
      wr.en     = acc && in_write && in_store;
      wr.region = in_region;
      wr.idx    = in_addr[12:0];
      wr.data   = (in_addr == ADDR_DIV) ? 8'd0 : in_data;
    end
  end

  cmbd_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .rd_value (rd_value),
    .clr_busy (clr_busy)
  );

  // Sprite DMA: each read issued here is written into the sprite table in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_active  <= 1'b0;
      dma_wr_pend <= 1'b0;
      dma_cnt     <= '0;
    end else begin
      dma_wr_pend <= dma_issue;
      if (dma_issue) begin
        dma_wr_idx <= dma_cnt;
        dma_cnt    <= dma_cnt + 8'd1;
      end
      if (acc && in_write && in_dma && !page_is_cart(in_data)) begin
        dma_active <= 1'b1;
        dma_cnt    <= '0;
        dma_src    <= in_data;
        dma_btn    <= in_btn;
        dma_dir    <= in_dir;
      end else if (dma_active && dma_cnt == SPR_BYTES && dma_wr_pend) begin
        dma_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_valid && out_free) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= s1_is_read ? rd_value : 8'd0;
        m_tuser[0] <= s1_cart;
        m_tuser[1] <= s1_dma_cart;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (acc) begin
        s1_valid    <= 1'b1;
        s1_is_read  <= !in_write;
        s1_cart     <= in_cart;
        s1_dma_cart <= in_write && in_dma && page_is_cart(in_data);
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  `CMBD_ASSERT_NOW(a_dma_tail, dma_active && dma_cnt == SPR_BYTES, dma_wr_pend, "DMA count ran past its last write")
  `CMBD_ASSERT_NOW(a_dma_no_read, dma_active, !(s1_valid && s1_is_read), "DMA overlaps a pending read")
  `CMBD_ASSERT_NOW(a_flags_excl, m_tvalid && m_tuser[1], !m_tuser[0], "DMA cart flag on a cart access")
  `CMBD_ASSERT_NEXT(a_dma_start, acc && in_write && in_dma && !page_is_cart(in_data), dma_active && !s_tready, "DMA did not start")

endmodule

### rtl/core/cmbd_store.sv
// Storage of the memory map: RAM arrays, clearing pass and read data shaping.
module cmbd_store (
  input  logic              clk,
  input  logic              rst,
  input  cmbd_pkg::rd_req_t rd,
  input  cmbd_pkg::wr_req_t wr,
  output logic [7:0]        rd_value,
  output logic              clr_busy
);
  import cmbd_pkg::*;

  logic [7:0] vram [0:8191];
  logic [7:0] wram [0:8191];
  logic [7:0] spr  [0:159];
  logic [7:0] io   [0:127];
  logic [7:0] hram [0:126];
  logic [7:0] ie;

  logic [12:0] clr_cnt;
  logic [7:0]  vram_q, wram_q, spr_q, io_q, hram_q;
  region_t     rd_region;
  region_t     rd_region_next;
  logic [3:0]  rd_btn, rd_dir;
  logic [3:0]  nib;

  assign rd_region_next = region_of(rd.addr);

  // Clearing pass walks every address of the largest arrays once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
      ie       <= '0;
    end else begin
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 13'd1;
        if (clr_cnt == 13'h1FFF) begin
          clr_busy <= 1'b0;
        end
      end else if (wr.en && wr.region == RG_IE) begin
        ie <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      vram[clr_cnt] <= '0;
      wram[clr_cnt] <= '0;
      if (clr_cnt < {5'd0, SPR_BYTES}) begin
        spr[clr_cnt[7:0]] <= '0;
      end
      if (clr_cnt < 13'd128) begin
        io[clr_cnt[6:0]] <= '0;
      end
      if (clr_cnt < 13'd127) begin
        hram[clr_cnt[6:0]] <= '0;
      end
    end else if (wr.en) begin
      case (wr.region)
        RG_VRAM: vram[wr.idx] <= wr.data;
        RG_WRAM: wram[wr.idx] <= wr.data;
        RG_SPR:  spr[wr.idx[7:0]] <= wr.data;
        RG_JOYP,
        RG_IO:   io[wr.idx[6:0]] <= wr.data;
        RG_HRAM: hram[wr.idx[6:0]] <= wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_region <= rd_region_next;
      rd_btn    <= rd.btn;
      rd_dir    <= rd.dir;
      case (rd_region_next)
        RG_VRAM: vram_q <= vram[rd.addr[12:0]];
        RG_WRAM: wram_q <= wram[rd.addr[12:0]];
        RG_SPR:  spr_q  <= spr[rd.addr[7:0]];
        RG_JOYP,
        RG_IO:   io_q   <= io[rd.addr[6:0]];
        RG_HRAM: hram_q <= hram[rd.addr[6:0]];
        default: ;
      endcase
    end
  end

  always_comb begin
    nib = 4'hF;
    if (!io_q[5]) nib = nib & rd_btn;
    if (!io_q[4]) nib = nib & rd_dir;
  end

  always_comb begin
    case (rd_region)
      RG_VRAM:   rd_value = vram_q;
      RG_WRAM:   rd_value = wram_q;
      RG_SPR:    rd_value = spr_q;
      RG_UNUSED: rd_value = 8'hFF;
      RG_JOYP:   rd_value = 8'hC0 | (io_q & JOYP_SEL_MASK) | {4'd0, nib};
      RG_IO:     rd_value = io_q;
      RG_HRAM:   rd_value = hram_q;
      RG_IE:     rd_value = ie;
      default:   rd_value = '0;
    endcase
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for the memory bus decoder: map, I/O quirks, sprite DMA, random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cmbd_pkg::*;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_kind_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       cart_request;
    logic       dma_from_cart;
  } bus_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // address[15:0], write_data[23:16], buttons[27:24], dpad[31:28]
  logic [0:0]  s_tuser = '0;   // action[0]
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [7:0]  m_tdata;        // read_data[7:0]
  logic [1:0]  m_tuser;        // cart_request[0], dma_from_cart[1]

  console_memory_bus_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of every store in the block, updated as words are accepted.
  logic [7:0] vram_copy [8192];
  logic [7:0] wram_copy [8192];
  logic [7:0] oam_copy  [160];
  logic [7:0] io_copy   [128];
  logic [7:0] hram_copy [127];
  logic [7:0] ie_copy;

  bus_result_t pending_results [$];
  logic [15:0] recent_writes [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatch_count     = 0;
  int results_checked    = 0;
  int reads_sent         = 0;
  int writes_sent        = 0;
  int dma_sent           = 0;
  int dma_cart_sent      = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic is_cart_addr(logic [15:0] a);
    return (a < 16'h8000) || (a >= 16'hA000 && a < 16'hC000);
  endfunction

  // Byte that a CPU read of address a returns, given the sampled joypad nibbles.
  function automatic logic [7:0] bus_peek(logic [15:0] a, logic [3:0] btn, logic [3:0] dir);
    logic [3:0] nib;
    logic [7:0] sel;
    nib = 4'hF;
    sel = io_copy[0];
    if (a < 16'h8000) return 8'h00;
    if (a < 16'hA000) return vram_copy[a - 16'h8000];
    if (a < 16'hC000) return 8'h00;
    if (a < ADDR_ECHO) return wram_copy[a - 16'hC000];
    if (a < 16'hFE00) return wram_copy[a - ADDR_ECHO];
    if (a < ADDR_UNUSABLE) return oam_copy[a - 16'hFE00];
    if (a < 16'hFF00) return 8'hFF;
    if (a == ADDR_JOYP) begin
      if (!sel[5]) nib &= btn;
      if (!sel[4]) nib &= dir;
      return 8'hC0 | (sel & JOYP_SEL_MASK) | {4'h0, nib};
    end
    if (a < ADDR_HRAM) return io_copy[a[6:0]];
    if (a < 16'hFFFF) return hram_copy[a - ADDR_HRAM];
    return ie_copy;
  endfunction

  // Applies one access to the shadow stores and returns the word the block should send.
  function automatic bus_result_t predict_access(access_kind_t kind, logic [15:0] addr,
                                                 logic [7:0] data, logic [3:0] btn,
                                                 logic [3:0] dir);
    bus_result_t r;
    logic [15:0] src;
    r = '0;
    r.cart_request = is_cart_addr(addr);
    if (kind == ACC_READ) begin
      r.read_data = bus_peek(addr, btn, dir);
    end else if (r.cart_request) begin
      // The external mapper owns cartridge writes.
    end else if (addr < 16'hA000) begin
      vram_copy[addr - 16'h8000] = data;
    end else if (addr < ADDR_ECHO) begin
      wram_copy[addr - 16'hC000] = data;
    end else if (addr < 16'hFE00) begin
      wram_copy[addr - ADDR_ECHO] = data;
    end else if (addr < ADDR_UNUSABLE) begin
      oam_copy[addr - 16'hFE00] = data;
    end else if (addr < 16'hFF00) begin
      // Unusable space drops writes.
    end else if (addr < ADDR_HRAM) begin
      if (addr == ADDR_DIV) begin
        io_copy[addr[6:0]] = 8'h00;
      end else if (addr == ADDR_LY) begin
        // The line counter is read-only.
      end else if (addr == ADDR_DMA) begin
        src = {data, 8'h00};
        if (is_cart_addr(src)) begin
          r.dma_from_cart = 1'b1;
        end else begin
          // Copy in order so a source page overlapping the sprite table sees earlier bytes.
          for (int i = 0; i < SPR_BYTES; i++) oam_copy[i] = bus_peek(src + 16'(i), btn, dir);
        end
      end else begin
        io_copy[addr[6:0]] = data;
      end
    end else if (addr < 16'hFFFF) begin
      hram_copy[addr - ADDR_HRAM] = data;
    end else begin
      ie_copy = data;
    end
    return r;
  endfunction

  task automatic send_access(input access_kind_t kind, input logic [15:0] addr,
                             input logic [7:0] data, input logic [3:0] btn,
                             input logic [3:0] dir);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {dir, btn, data, addr};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_access(kind, addr, data, btn, dir));
    if (kind == ACC_READ) begin
      reads_sent++;
    end else begin
      writes_sent++;
      if (addr == ADDR_DMA) begin
        dma_sent++;
        if (is_cart_addr({data, 8'h00})) dma_cart_sent++;
      end
      recent_writes.push_back(addr);
      if (recent_writes.size() > 16) void'(recent_writes.pop_front());
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin : check_results
    bus_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("ERROR: unexpected result word data=%02h user=%b", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata != want.read_data || m_tuser[0] != want.cart_request ||
            m_tuser[1] != want.dma_from_cart) begin
          if (mismatch_count < 10)
            $display("ERROR: result %0d expected data=%02h cart=%b dma_cart=%b, got data=%02h cart=%b dma_cart=%b",
                     results_checked, want.read_data, want.cart_request, want.dma_from_cart,
                     m_tdata, m_tuser[0], m_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic [15:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      if ($urandom_range(1)) return 16'($urandom_range(16'h7FFF));
      return 16'hA000 + 16'($urandom_range(16'h1FFF));
    end
    if (roll < 20) return 16'h8000 + 16'($urandom_range(16'h1FFF));
    if (roll < 35) return 16'hC000 + 16'($urandom_range(16'h1FFF));
    if (roll < 45) return ADDR_ECHO + 16'($urandom_range(16'h1DFF));
    if (roll < 55) return 16'hFE00 + 16'($urandom_range(159));
    if (roll < 60) return ADDR_UNUSABLE + 16'($urandom_range(16'h5F));
    if (roll < 75) begin
      case ($urandom_range(4))
        0:       return ADDR_JOYP;
        1:       return ADDR_DIV;
        2:       return ADDR_LY;
        default: return 16'hFF00 + 16'($urandom_range(16'h7F));
      endcase
    end
    if (roll < 90) return ADDR_HRAM + 16'($urandom_range(126));
    if (roll < 95) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_dma_page();
    if ($urandom_range(4) == 0) begin
      if ($urandom_range(1)) return 8'($urandom_range(8'h7F));
      return 8'hA0 + 8'($urandom_range(8'h1F));
    end
    if ($urandom_range(1)) return 8'h80 + 8'($urandom_range(31));
    return 8'hC0 + 8'($urandom_range(63));
  endfunction

  task automatic test_memory_map();
    send_access(ACC_READ,  16'h0000, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, 16'hBFFF, 8'h99, 4'hF, 4'hF);
    send_access(ACC_WRITE, 16'h8000, 8'hA5, 4'hF, 4'hF);
    send_access(ACC_READ,  16'h8000, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, 16'hC000, 8'h3C, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_ECHO, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, 16'hFE9F, 8'h81, 4'hF, 4'hF);
    send_access(ACC_WRITE, ADDR_UNUSABLE, 8'h12, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_UNUSABLE, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, ADDR_HRAM, 8'h42, 4'hF, 4'hF);
    send_access(ACC_WRITE, 16'hFFFF, 8'hFF, 4'hF, 4'hF);
    send_access(ACC_READ,  16'hFFFF, 8'h00, 4'hF, 4'hF);
  endtask

  task automatic test_io_registers();
    // Select the button nibble, then the direction nibble.
    send_access(ACC_WRITE, ADDR_JOYP, 8'h10, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_JOYP, 8'h00, 4'h5, 4'hA);
    send_access(ACC_WRITE, ADDR_JOYP, 8'h20, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_JOYP, 8'h00, 4'h0, 4'h6);
    send_access(ACC_WRITE, ADDR_DIV, 8'h77, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_DIV, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, ADDR_LY, 8'h99, 4'hF, 4'hF);
    send_access(ACC_READ,  ADDR_LY, 8'h00, 4'hF, 4'hF);
  endtask

  task automatic test_sprite_dma();
    send_access(ACC_WRITE, ADDR_DMA, 8'hC0, 4'hF, 4'hF);
    send_access(ACC_READ,  16'hFE00, 8'h00, 4'hF, 4'hF);
    send_access(ACC_WRITE, ADDR_DMA, 8'h7F, 4'hF, 4'hF);
    send_access(ACC_WRITE, ADDR_DMA, 8'hA0, 4'hF, 4'hF);
    // The top page pulls in the joypad register, so the nibbles matter here.
    send_access(ACC_WRITE, ADDR_DMA, 8'hFF, 4'h3, 4'hC);
  endtask

  task automatic test_random_traffic(input int count);
    access_kind_t kind;
    logic [15:0]  addr;
    logic [7:0]   data;
    for (int n = 0; n < count; n++) begin
      data = 8'($urandom);
      if ($urandom_range(99) < 4) begin
        kind = ACC_WRITE;
        addr = ADDR_DMA;
        data = pick_dma_page();
      end else begin
        kind = $urandom_range(1) ? ACC_WRITE : ACC_READ;
        // Half the reads revisit a recently written address to check stored data.
        if (kind == ACC_READ && recent_writes.size() != 0 && $urandom_range(1))
          addr = recent_writes[$urandom_range(recent_writes.size() - 1)];
        else
          addr = pick_address();
      end
      send_access(kind, addr, data, 4'($urandom), 4'($urandom));
    end
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    test_random_traffic(count);
    wait_results_done();
  endtask

  initial begin
    foreach (vram_copy[i]) vram_copy[i] = 8'h00;
    foreach (wram_copy[i]) wram_copy[i] = 8'h00;
    foreach (oam_copy[i]) oam_copy[i] = 8'h00;
    foreach (io_copy[i]) io_copy[i] = 8'h00;
    foreach (hram_copy[i]) hram_copy[i] = 8'h00;
    ie_copy = 8'h00;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_memory_map();
    test_io_registers();
    test_sprite_dma();
    wait_results_done();

    run_random_phase(0, 0, 150);
    run_random_phase(61, 0, 150);
    run_random_phase(0, 61, 150);
    run_random_phase(15, 15, 150);

    repeat (8) @(posedge clk);
    $display("Covered %0d reads and %0d writes, %0d of them sprite DMA starts (%0d from cartridge pages).",
             reads_sent, writes_sent, dma_sent, dma_cart_sent);
    $display("Checked %0d result words across idle, sender-gap, receiver-stall and mixed phases.",
             results_checked);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### console_memory_bus_decoder_core.f
+incdir+rtl/core
rtl/core/cmbd_pkg.sv
rtl/core/cmbd_store.sv
rtl/core/console_memory_bus_decoder_core.sv
tb/tb_top.sv
